### hdl/lenode_pkg.sv
// Shared types and constants for the leader election node.
// Used by lenode_front, lenode_back and the top level; depends on nothing.
`default_nettype none

package lenode_pkg;

   localparam int MAX_NODES_DEFAULT = 32;

   localparam logic [15:0] ELECTION_MAX_RESET     = 16'd1000;
   localparam logic [15:0] HEARTBEAT_PERIOD_RESET = 16'd500;

   typedef enum logic [1:0] {
      OP_TICK      = 2'd0,
      OP_VOTE_REQ  = 2'd1,
      OP_VOTE_RSP  = 2'd2,
      OP_AUTHORITY = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      KIND_NONE      = 2'd0,
      KIND_VOTE_REQ  = 2'd1,
      KIND_VOTE_RSP  = 2'd2,
      KIND_AUTHORITY = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ROLE_FOLLOWER  = 2'd0,
      ROLE_CANDIDATE = 2'd1,
      ROLE_LEADER    = 2'd2
   } role_type;

   typedef enum logic [1:0] {
      CSR_OWN_NODE         = 2'd0,
      CSR_ELECTION_MAX     = 2'd1,
      CSR_HEARTBEAT_PERIOD = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic          valid;
      csr_index_type index;
      logic [15:0]   data;
   } csr_write_type;

   // classified input item, as queued between front and back
   typedef struct packed {
      op_type      op;
      logic [31:0] msg_term;
      logic [4:0]  sender_node;
      logic [4:0]  vote_for_node;
      logic [4:0]  member_count;
      logic [15:0] fresh_timeout;
   } req_item_type;

   typedef struct packed {
      kind_type    send_kind;
      logic [31:0] send_term;
      logic [4:0]  vote_target;
      logic        vote_granted;
      role_type    role;
      logic        leader_known;
      logic [4:0]  leader_node;
      logic        leader_switched;
      logic        leader_conflict;
   } rsp_item_type;

endpackage

`default_nettype wire

### hdl/lenode_fifo.sv
// Two-entry register queue with full/empty flags.
// Generic over payload width; no package dependency.
`default_nettype none

module lenode_fifo #(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] pop_data,
   output logic                  empty
);

   logic [WIDTH-1:0] slot_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

### hdl/lenode_front.sv
// Front end: decodes the incoming message kind and queues the item.
// Depends on lenode_pkg and lenode_fifo.
`default_nettype none

module lenode_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_push,
   output logic                     req_full,
   input  wire logic [1:0]          req_func,
   input  wire logic [31:0]         req_msg_term,
   input  wire logic [4:0]          req_sender_node,
   input  wire logic [4:0]          req_vote_for_node,
   input  wire logic [4:0]          req_member_count,
   input  wire logic [15:0]         req_fresh_timeout,
   output lenode_pkg::req_item_type item,
   output logic                     item_empty,
   input  wire logic                item_pop
);

   import lenode_pkg::*;

   req_item_type in_item;
   op_type       op;

   always_comb begin
      unique case (req_func)
         2'd0:    op = OP_TICK;
         2'd1:    op = OP_VOTE_REQ;
         2'd2:    op = OP_VOTE_RSP;
         default: op = OP_AUTHORITY;
      endcase
   end

   always_comb begin
      in_item.op            = op;
      in_item.msg_term      = req_msg_term;
      in_item.sender_node   = req_sender_node;
      in_item.vote_for_node = req_vote_for_node;
      in_item.member_count  = req_member_count;
      in_item.fresh_timeout = req_fresh_timeout;
   end

   lenode_fifo #(
      .WIDTH($bits(req_item_type))
   ) u_req_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (req_push),
      .push_data(in_item),
      .full     (req_full),
      .pop      (item_pop),
      .pop_data (item),
      .empty    (item_empty)
   );

endmodule

`default_nettype wire

### hdl/lenode_back.sv
// Back end: election state, config registers and the result queue.
// Depends on lenode_pkg and lenode_fifo.
`default_nettype none

module lenode_back #(
   parameter int MAX_NODES = lenode_pkg::MAX_NODES_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire lenode_pkg::csr_write_type csr,
   input  wire lenode_pkg::req_item_type  item,
   input  wire logic                     item_empty,
   output logic                          item_pop,
   output lenode_pkg::rsp_item_type      rsp_item,
   output logic                          rsp_empty,
   input  wire logic                     rsp_pop
);

   import lenode_pkg::*;

   localparam int VOTE_W = $clog2(MAX_NODES + 1);

   // config
   logic [4:0]  own_node_ff;
   logic [15:0] election_max_ff;
   logic [15:0] heartbeat_period_ff;

   // election state
   role_type            role_ff, role_in;
   logic [31:0]         term_ff, term_in;
   logic [15:0]         etimer_ff, etimer_in;
   logic [15:0]         htimer_ff, htimer_in;
   logic [MAX_NODES-1:0] voters_ff, voters_in;
   logic [VOTE_W-1:0]   voting_ff, voting_in;
   logic [VOTE_W-1:0]   votes_ff, votes_in;
   logic                lvalid_ff, lvalid_in;
   logic [4:0]          lindex_ff, lindex_in;

   logic                 rsp_full;
   logic                 fire;
   logic [15:0]          etimer_dec, htimer_dec;
   logic [MAX_NODES-1:0] own_bit, sender_bit;
   logic                 new_vote;
   logic [VOTE_W-1:0]    votes_next;
   logic [VOTE_W-1:0]    majority;
   logic [VOTE_W-1:0]    voting_sat;
   logic [31:0]          members_plus;
   rsp_item_type         out_item;

   assign fire     = !item_empty && !rsp_full;
   assign item_pop = fire;

   assign etimer_dec = (etimer_ff != 16'd0) ? etimer_ff - 16'd1 : 16'd0;
   assign htimer_dec = (htimer_ff != 16'd0) ? htimer_ff - 16'd1 : 16'd0;

   always_comb begin
      for (int i = 0; i < MAX_NODES; i++) begin
         own_bit[i]    = (32'(own_node_ff) == i);
         sender_bit[i] = (32'(item.sender_node) == i);
      end
   end

   // running count of distinct voters, so no population count is needed
   assign new_vote     = |(sender_bit & ~voters_ff);
   assign votes_next   = votes_ff + VOTE_W'(new_vote);
   assign majority     = (voting_ff >> 1) + VOTE_W'(1);
   assign members_plus = 32'(item.member_count) + 32'd1;
   assign voting_sat   = (members_plus > 32'(MAX_NODES)) ? VOTE_W'(MAX_NODES)
                                                        : VOTE_W'(members_plus);

   always_comb begin
      role_in   = role_ff;
      term_in   = term_ff;
      etimer_in = etimer_ff;
      htimer_in = htimer_ff;
      voters_in = voters_ff;
      voting_in = voting_ff;
      votes_in  = votes_ff;
      lvalid_in = lvalid_ff;
      lindex_in = lindex_ff;

      out_item.send_kind       = KIND_NONE;
      out_item.send_term       = 32'd0;
      out_item.vote_target     = 5'd0;
      out_item.vote_granted    = 1'b0;
      out_item.leader_switched = 1'b0;
      out_item.leader_conflict = 1'b0;

      if (fire) begin
         unique case (item.op)
            OP_TICK: begin
               etimer_in = etimer_dec;
               htimer_in = htimer_dec;
               unique case (role_ff)
                  ROLE_FOLLOWER: begin
                     if (etimer_dec == 16'd0) begin
                        out_item.leader_switched = lvalid_ff;
                        lvalid_in = 1'b0;
                        lindex_in = 5'd0;
                        role_in   = ROLE_CANDIDATE;
                        voting_in = voting_sat;
                        term_in   = term_ff + 32'd1;
                        voters_in = own_bit;
                        votes_in  = VOTE_W'(|own_bit);
                        etimer_in = election_max_ff;
                        out_item.send_kind = KIND_VOTE_REQ;
                        out_item.send_term = term_ff + 32'd1;
                     end
                  end
                  ROLE_CANDIDATE: begin
                     if (etimer_dec == 16'd0) begin
                        role_in   = ROLE_FOLLOWER;
                        etimer_in = election_max_ff;
                     end
                  end
                  default: begin
                     if (htimer_dec == 16'd0) begin
                        out_item.send_kind = KIND_AUTHORITY;
                        out_item.send_term = term_ff;
                        htimer_in = heartbeat_period_ff;
                        out_item.leader_switched = !lvalid_ff || (lindex_ff != own_node_ff);
                        lvalid_in = 1'b1;
                        lindex_in = own_node_ff;
                     end
                  end
               endcase
            end
            OP_VOTE_REQ: begin
               if (role_ff == ROLE_FOLLOWER) begin
                  if (term_ff < item.msg_term && item.sender_node != own_node_ff) begin
                     term_in   = item.msg_term;
                     etimer_in = item.fresh_timeout;
                     out_item.send_kind    = KIND_VOTE_RSP;
                     out_item.send_term    = item.msg_term;
                     out_item.vote_target  = item.sender_node;
                     out_item.vote_granted = 1'b1;
                  end
               end else if (item.msg_term >= term_ff) begin
                  role_in   = ROLE_FOLLOWER;
                  term_in   = item.msg_term;
                  etimer_in = item.fresh_timeout;
                  out_item.send_kind    = KIND_VOTE_RSP;
                  out_item.send_term    = item.msg_term;
                  out_item.vote_target  = item.sender_node;
                  out_item.vote_granted = 1'b1;
               end else begin
                  out_item.send_kind   = KIND_VOTE_RSP;
                  out_item.send_term   = term_ff;
                  out_item.vote_target = item.sender_node;
               end
            end
            OP_VOTE_RSP: begin
               if (role_ff == ROLE_CANDIDATE && item.msg_term == term_ff
                   && item.vote_for_node == own_node_ff) begin
                  voters_in = voters_ff | sender_bit;
                  votes_in  = votes_next;
                  if (votes_next >= majority) begin
                     role_in = ROLE_LEADER;
                     out_item.send_kind = KIND_AUTHORITY;
                     out_item.send_term = term_ff;
                     out_item.leader_switched = !lvalid_ff || (lindex_ff != own_node_ff);
                     lvalid_in = 1'b1;
                     lindex_in = own_node_ff;
                  end
               end
            end
            OP_AUTHORITY: begin
               if (role_ff != ROLE_LEADER) begin
                  role_in = ROLE_FOLLOWER;
                  out_item.leader_conflict = (term_ff >= item.msg_term) && lvalid_ff
                                             && (lindex_ff != item.sender_node);
                  term_in   = item.msg_term;
                  etimer_in = item.fresh_timeout;
                  out_item.leader_switched = !lvalid_ff || (lindex_ff != item.sender_node);
                  lvalid_in = 1'b1;
                  lindex_in = item.sender_node;
               end
            end
         endcase
      end

      out_item.role         = role_in;
      out_item.leader_known = lvalid_in;
      out_item.leader_node  = lvalid_in ? lindex_in : 5'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_node_ff         <= 5'd0;
         election_max_ff     <= ELECTION_MAX_RESET;
         heartbeat_period_ff <= HEARTBEAT_PERIOD_RESET;
      end else if (csr.valid) begin
         unique case (csr.index)
            CSR_OWN_NODE:         own_node_ff         <= csr.data[4:0];
            CSR_ELECTION_MAX:     election_max_ff     <= csr.data;
            CSR_HEARTBEAT_PERIOD: heartbeat_period_ff <= csr.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         role_ff   <= ROLE_FOLLOWER;
         term_ff   <= 32'd0;
         etimer_ff <= ELECTION_MAX_RESET;
         htimer_ff <= HEARTBEAT_PERIOD_RESET;
         voters_ff <= '0;
         voting_ff <= '0;
         votes_ff  <= '0;
         lvalid_ff <= 1'b0;
         lindex_ff <= 5'd0;
      end else begin
         role_ff   <= role_in;
         term_ff   <= term_in;
         etimer_ff <= etimer_in;
         htimer_ff <= htimer_in;
         voters_ff <= voters_in;
         voting_ff <= voting_in;
         votes_ff  <= votes_in;
         lvalid_ff <= lvalid_in;
         lindex_ff <= lindex_in;
      end
   end

   lenode_fifo #(
      .WIDTH($bits(rsp_item_type))
   ) u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (fire),
      .push_data(out_item),
      .full     (rsp_full),
      .pop      (rsp_pop),
      .pop_data (rsp_item),
      .empty    (rsp_empty)
   );

endmodule

`default_nettype wire

### hdl/leader_election_node.sv
// Top level of the leader election node: front end, back end and ports.
// Depends on lenode_pkg, lenode_front and lenode_back.
//
//   channel  handshake          accepted when         payload
//   req      req_push/req_full  push && !full         func, term, sender, ...
//   rsp      rsp_empty/rsp_pop  pop && !empty         send_kind, role, leader, ...
//   csr      csr_valid/ready    valid && ready        csr_index, csr_data
//
// One item per cycle sustained while the rsp side keeps popping. An accepted
// item is registered in the request queue; the state update then writes its
// result into the result queue, whose head drives the rsp ports. Both queues
// hold two items, so either side may stall without stopping the other until
// its queue fills. csr_ready is always high. Reset is synchronous; no
// clearing pass.
`default_nettype none

module leader_election_node #(
   parameter int MAX_NODES = lenode_pkg::MAX_NODES_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [1:0]  req_func,
   input  wire logic [31:0] req_msg_term,
   input  wire logic [4:0]  req_sender_node,
   input  wire logic [4:0]  req_vote_for_node,
   input  wire logic [4:0]  req_member_count,
   input  wire logic [15:0] req_fresh_timeout,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [1:0]       rsp_send_kind,
   output logic [31:0]      rsp_send_term,
   output logic [4:0]       rsp_vote_target,
   output logic             rsp_vote_granted,
   output logic [1:0]       rsp_role,
   output logic             rsp_leader_known,
   output logic [4:0]       rsp_leader_node,
   output logic             rsp_leader_switched,
   output logic             rsp_leader_conflict,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_data
);

   import lenode_pkg::*;

   req_item_type  item;
   logic          item_empty;
   logic          item_pop;
   rsp_item_type  rsp_item;
   csr_write_type csr;

   assign csr_ready = 1'b1;

   always_comb begin
      csr.valid = csr_valid;
      csr.index = csr_index_type'(csr_index);
      csr.data  = csr_data;
   end

   lenode_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_func         (req_func),
      .req_msg_term     (req_msg_term),
      .req_sender_node  (req_sender_node),
      .req_vote_for_node(req_vote_for_node),
      .req_member_count (req_member_count),
      .req_fresh_timeout(req_fresh_timeout),
      .item             (item),
      .item_empty       (item_empty),
      .item_pop         (item_pop)
   );

   lenode_back #(
      .MAX_NODES(MAX_NODES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr),
      .item      (item),
      .item_empty(item_empty),
      .item_pop  (item_pop),
      .rsp_item  (rsp_item),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop)
   );

   assign rsp_send_kind       = rsp_item.send_kind;
   assign rsp_send_term       = rsp_item.send_term;
   assign rsp_vote_target     = rsp_item.vote_target;
   assign rsp_vote_granted    = rsp_item.vote_granted;
   assign rsp_role            = rsp_item.role;
   assign rsp_leader_known    = rsp_item.leader_known;
   assign rsp_leader_node     = rsp_item.leader_node;
   assign rsp_leader_switched = rsp_item.leader_switched;
   assign rsp_leader_conflict = rsp_item.leader_conflict;

endmodule

`default_nettype wire
